// File: rtl/ccws_pkg.sv
package ccws_pkg;

    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_SLASH  = 3'd1;
    localparam logic [2:0] MODE_LINE   = 3'd2;
    localparam logic [2:0] MODE_BLOCK  = 3'd3;
    localparam logic [2:0] MODE_STAR   = 3'd4;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_TICK      = 8'h27;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = 2;

    typedef struct packed {
        logic [2:0] mode;
        logic       ws_run;
        logic       in_str;
        logic [7:0] prev;
        logic       have_prev;
    } scan_state_t;

    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] ch0;
        logic [7:0] ch1;
    } step_result_t;

    localparam scan_state_t SCAN_RESET = '{
        mode:      MODE_NORMAL,
        ws_run:    1'b0,
        in_str:    1'b0,
        prev:      8'h00,
        have_prev: 1'b0
    };

endpackage

// File: rtl/ccws_step.sv
module ccws_step (
    input  ccws_pkg::scan_state_t  cur,
    input  logic                   kind,
    input  logic [7:0]             data,
    output ccws_pkg::scan_state_t  nxt,
    output ccws_pkg::step_result_t res
);
    import ccws_pkg::*;

    logic       pre_slash;
    logic       do_plain;
    logic       ws_in;
    logic       p_emit;
    logic [7:0] p_char;
    logic       keep;
    logic       is_space;

    assign is_space = (data == CH_SPACE) || (data == CH_TAB) ||
                      (data == CH_LF) || (data == CH_CR);

    always_comb
    begin
        nxt       = cur;
        pre_slash = 1'b0;
        do_plain  = 1'b0;
        p_emit    = 1'b0;
        p_char    = data;
        keep      = 1'b0;
        if (kind)
        begin
            nxt       = SCAN_RESET;
            pre_slash = (cur.mode == MODE_SLASH);
        end
        else
        begin
            case (cur.mode)
                MODE_SLASH:
                begin
                    if (data == CH_SLASH)
                        nxt.mode = MODE_LINE;
                    else if (data == CH_STAR)
                        nxt.mode = MODE_BLOCK;
                    else
                    begin
                        pre_slash = 1'b1;
                        do_plain  = 1'b1;
                    end
                end
                MODE_LINE:
                begin
                    if (data == CH_LF)
                        nxt.mode = MODE_NORMAL;
                end
                MODE_BLOCK:
                begin
                    if (data == CH_STAR)
                        nxt.mode = MODE_STAR;
                end
                MODE_STAR:
                begin
                    if (data == CH_SLASH)
                        nxt.mode = MODE_NORMAL;
                    else if (data != CH_STAR)
                        nxt.mode = MODE_BLOCK;
                end
                default:
                begin
                    do_plain = 1'b1;
                end
            endcase
            nxt.prev      = data;
            nxt.have_prev = 1'b1;
        end

        ws_in = pre_slash ? 1'b0 : cur.ws_run;
        if (do_plain)
        begin
            nxt.mode   = MODE_NORMAL;
            nxt.ws_run = ws_in;
            if (data == CH_QUOTE)
            begin
                p_emit = 1'b1;
                if (cur.have_prev)
                    keep = (cur.in_str && cur.prev == CH_BACKSLASH) ||
                           (!cur.in_str && cur.prev == CH_TICK);
                if (!keep)
                    nxt.in_str = ~cur.in_str;
                nxt.ws_run = 1'b0;
            end
            else if (cur.in_str)
            begin
                p_emit = 1'b1;
            end
            else if (data == CH_SLASH)
            begin
                nxt.mode = MODE_SLASH;
            end
            else if (is_space)
            begin
                p_emit     = ~ws_in;
                p_char     = CH_SPACE;
                nxt.ws_run = 1'b1;
            end
            else
            begin
                p_emit     = 1'b1;
                nxt.ws_run = 1'b0;
            end
        end

        if (pre_slash)
        begin
            res.ch0 = CH_SLASH;
            res.ch1 = p_char;
            res.cnt = 2'd1 + {1'b0, do_plain & p_emit};
        end
        else
        begin
            res.ch0 = p_char;
            res.ch1 = p_char;
            res.cnt = {1'b0, do_plain & p_emit};
        end
    end

endmodule

// File: rtl/ccws_fifo.sv
module ccws_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ccws_pkg::step_result_t push_res,
    output logic                   full,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             out_char,
    output logic                   run_last
);
    import ccws_pkg::*;

    logic [8:0]         mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_reg;
    logic [FIFO_AW-1:0] rd_reg;
    logic [FIFO_AW:0]   count_reg;
    logic [FIFO_AW:0]   count_next;
    logic               pop;
    logic [FIFO_AW-1:0] wr_plus1;

    assign full      = count_reg > (FIFO_AW + 1)'(FIFO_DEPTH - 2);
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign out_char  = mem_reg[rd_reg][8:1];
    assign run_last  = mem_reg[rd_reg][0];
    assign wr_plus1  = wr_reg + 1'b1;

    assign count_next = count_reg + {1'b0, push_res.cnt} - {{FIFO_AW{1'b0}}, pop};

    always_ff @(posedge clk)
    begin
        if (push_res.cnt != 2'd0)
            mem_reg[wr_reg] <= {push_res.ch0, push_res.cnt == 2'd1};
        if (push_res.cnt == 2'd2)
            mem_reg[wr_plus1] <= {push_res.ch1, 1'b1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_reg + push_res.cnt[FIFO_AW-1:0];
            rd_reg    <= rd_reg + {{(FIFO_AW-1){1'b0}}, pop};
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, count_reg} + {2'b00, push_res.cnt} <= (FIFO_AW + 2)'(FIFO_DEPTH))
        else $error("Result queue overflow.");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && push_res.cnt == 2'd0) |=>
            count_reg == $past(count_reg) - {{FIFO_AW{1'b0}}, 1'b1})
        else $error("Queue count did not drop after a lone read.");

endmodule

// File: rtl/c_comment_whitespace_stripper.sv
// C comment and whitespace stripper.
// The input channel (in_valid, in_stall, kind, data) takes one source byte,
// or an end-of-stream marker when kind is high, per transaction.
// The output channel (out_valid, out_stall, out_char, run_last) delivers the
// filtered bytes; run_last marks the final byte caused by one input
// transaction. An input transaction causes zero, one or two output bytes.
// Each accepted byte updates the scanner state in the same cycle and its
// results enter a four-entry result queue, whose head drives the output.
// Throughput is one input byte per cycle while the receiver takes one byte
// per cycle; a held slash followed by a plain byte makes two results, which
// the output drains at one per cycle. in_stall rises while the queue holds
// more than two results, so when the receiver stalls the block accepts
// until the queue can no longer take the worst case of two results.
// Reset clears the scanner state and empties the queue. An end-of-stream
// transaction flushes a held slash and returns the scanner to its reset state.
module c_comment_whitespace_stripper (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       kind,
    input  logic [7:0] data,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       run_last
);
    import ccws_pkg::*;

    scan_state_t  st_reg;
    scan_state_t  st_next;
    step_result_t step_res;
    step_result_t push_res;
    logic         full;
    logic         in_accept;

    assign in_stall  = full;
    assign in_accept = in_valid && !full;

    ccws_step u_step (
        .cur  (st_reg),
        .kind (kind),
        .data (data),
        .nxt  (st_next),
        .res  (step_res)
    );

    always_comb
    begin
        push_res = step_res;
        if (!in_accept)
            push_res.cnt = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= SCAN_RESET;
        else if (in_accept)
            st_reg <= st_next;
    end

    ccws_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_res  (push_res),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .run_last  (run_last)
    );

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && kind) |=> (st_reg.mode == MODE_NORMAL && !st_reg.in_str &&
                                 !st_reg.have_prev))
        else $error("End of stream did not restore the scanner state.");

    a_comment_outside_string: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.mode != MODE_NORMAL) |-> !st_reg.in_str)
        else $error("Comment or held slash inside a string.");

endmodule

// File: test/tb_c_comment_whitespace_stripper.sv
`timescale 1ns / 100ps

module tb_c_comment_whitespace_stripper;

    import ccws_pkg::*;

    localparam int NUM_DIRECTED = 26;
    localparam int RANDOM_ITEMS = 1550;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int IDLE_PERCENT = 35;

    typedef struct {
        logic       kind;
        logic [7:0] data;
        bit         typed;
        int         count;
        logic [7:0] c0;
        logic [7:0] c1;
    } stim_item_t;

    typedef struct {
        logic [7:0] ch;
        logic       is_last;
    } filtered_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       kind = 1'b0;
    logic [7:0] data = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_char;
    logic       run_last;

    logic running = 1'b0;
    logic steady;

    stim_item_t stim_q[$];
    filtered_t  filtered_q[$];
    logic [7:0] step_chars[$];

    int next_idx = 0;
    int cur_idx = 0;
    int accepted_items = 0;
    int end_items = 0;
    int results_checked = 0;
    int error_count = 0;
    int cycle_count = 0;

    logic [2:0] scan_mode;
    logic       ws_run;
    logic       in_str;
    logic [7:0] prev_byte;
    logic       have_prev;

    stim_item_t directed_rows [NUM_DIRECTED] = '{
        '{1'b0, CH_QUOTE,     1'b1, 1, CH_QUOTE,     8'h00},
        '{1'b0, CH_BACKSLASH, 1'b1, 1, CH_BACKSLASH, 8'h00},
        '{1'b0, CH_QUOTE,     1'b1, 1, CH_QUOTE,     8'h00},
        '{1'b0, 8'hFF,        1'b1, 1, 8'hFF,        8'h00},
        '{1'b0, CH_SLASH,     1'b0, 0, 8'h00,        8'h00},
        '{1'b0, CH_QUOTE,     1'b1, 1, CH_QUOTE,     8'h00},
        '{1'b0, CH_TICK,      1'b1, 1, CH_TICK,      8'h00},
        '{1'b0, CH_QUOTE,     1'b0, 0, 8'h00,        8'h00},
        '{1'b0, 8'h00,        1'b1, 1, 8'h00,        8'h00},
        '{1'b0, CH_SPACE,     1'b1, 1, CH_SPACE,     8'h00},
        '{1'b0, CH_TAB,       1'b1, 0, 8'h00,        8'h00},
        '{1'b0, CH_SLASH,     1'b1, 0, 8'h00,        8'h00},
        '{1'b0, CH_STAR,      1'b1, 0, 8'h00,        8'h00},
        '{1'b0, CH_STAR,      1'b0, 0, 8'h00,        8'h00},
        '{1'b0, CH_STAR,      1'b0, 0, 8'h00,        8'h00},
        '{1'b0, CH_SLASH,     1'b0, 0, 8'h00,        8'h00},
        '{1'b0, CH_LF,        1'b0, 0, 8'h00,        8'h00},
        '{1'b0, CH_SLASH,     1'b0, 0, 8'h00,        8'h00},
        '{1'b0, CH_SLASH,     1'b0, 0, 8'h00,        8'h00},
        '{1'b0, 8'h78,        1'b0, 0, 8'h00,        8'h00},
        '{1'b0, CH_LF,        1'b0, 0, 8'h00,        8'h00},
        '{1'b0, CH_SLASH,     1'b0, 0, 8'h00,        8'h00},
        '{1'b0, 8'h61,        1'b1, 2, CH_SLASH,     8'h61},
        '{1'b0, CH_SLASH,     1'b0, 0, 8'h00,        8'h00},
        '{1'b1, 8'hA5,        1'b1, 1, CH_SLASH,     8'h00},
        '{1'b1, 8'h00,        1'b1, 0, 8'h00,        8'h00}
    };

    c_comment_whitespace_stripper i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .data      (data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .run_last  (run_last)
    );

    always #2 clk = ~clk;

    assign steady = (accepted_items >= 700) && (accepted_items < 1000);

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
    endfunction

    function void clear_scanner();
        scan_mode = MODE_NORMAL;
        ws_run    = 1'b0;
        in_str    = 1'b0;
        prev_byte = 8'h00;
        have_prev = 1'b0;
    endfunction

    function void plain_char(input logic [7:0] b);
        logic keep;
        keep = 1'b0;
        if (b == CH_QUOTE)
        begin
            step_chars.push_back(b);
            if (have_prev)
                keep = (in_str && prev_byte == CH_BACKSLASH) ||
                       (!in_str && prev_byte == CH_TICK);
            if (!keep)
                in_str = !in_str;
            ws_run = 1'b0;
        end
        else if (in_str)
            step_chars.push_back(b);
        else if (b == CH_SLASH)
            scan_mode = MODE_SLASH;
        else if (is_blank(b))
        begin
            if (!ws_run)
                step_chars.push_back(CH_SPACE);
            ws_run = 1'b1;
        end
        else
        begin
            step_chars.push_back(b);
            ws_run = 1'b0;
        end
    endfunction

    function void strip_byte(input logic end_of_stream, input logic [7:0] b);
        step_chars.delete();
        if (end_of_stream)
        begin
            if (scan_mode == MODE_SLASH)
                step_chars.push_back(CH_SLASH);
            clear_scanner();
        end
        else
        begin
            case (scan_mode)
                MODE_SLASH:
                begin
                    if (b == CH_SLASH)
                        scan_mode = MODE_LINE;
                    else if (b == CH_STAR)
                        scan_mode = MODE_BLOCK;
                    else
                    begin
                        step_chars.push_back(CH_SLASH);
                        ws_run = 1'b0;
                        scan_mode = MODE_NORMAL;
                        plain_char(b);
                    end
                end
                MODE_LINE:
                begin
                    if (b == CH_LF)
                        scan_mode = MODE_NORMAL;
                end
                MODE_BLOCK:
                begin
                    if (b == CH_STAR)
                        scan_mode = MODE_STAR;
                end
                MODE_STAR:
                begin
                    if (b == CH_SLASH)
                        scan_mode = MODE_NORMAL;
                    else if (b != CH_STAR)
                        scan_mode = MODE_BLOCK;
                end
                default:
                begin
                    scan_mode = MODE_NORMAL;
                    plain_char(b);
                end
            endcase
            prev_byte = b;
            have_prev = 1'b1;
        end
    endfunction

    function void add_byte(input logic [7:0] b);
        stim_item_t item;
        item = '{1'b0, b, 1'b0, 0, 8'h00, 8'h00};
        stim_q.push_back(item);
    endfunction

    function void add_end();
        stim_item_t item;
        item = '{1'b1, 8'($urandom_range(255)), 1'b0, 0, 8'h00, 8'h00};
        stim_q.push_back(item);
    endfunction

    function automatic logic [7:0] printable();
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    always @(posedge clk)
    begin
        if (running)
        begin
            if (in_valid && !in_stall)
            begin
                strip_byte(stim_q[cur_idx].kind, stim_q[cur_idx].data);
                if (stim_q[cur_idx].typed)
                begin
                    if (stim_q[cur_idx].count > 0)
                        filtered_q.push_back('{stim_q[cur_idx].c0,
                                               stim_q[cur_idx].count == 1});
                    if (stim_q[cur_idx].count > 1)
                        filtered_q.push_back('{stim_q[cur_idx].c1, 1'b1});
                end
                else
                begin
                    foreach (step_chars[i])
                        filtered_q.push_back('{step_chars[i], i == step_chars.size() - 1});
                end
                if (stim_q[cur_idx].kind)
                    end_items++;
                accepted_items++;
            end
            if (!in_valid || !in_stall)
            begin
                if (next_idx < stim_q.size() &&
                    (steady || $urandom_range(99) >= IDLE_PERCENT))
                begin
                    kind     <= stim_q[next_idx].kind;
                    data     <= stim_q[next_idx].data;
                    in_valid <= 1'b1;
                    cur_idx  = next_idx;
                    next_idx++;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        filtered_t want;
        if (running)
        begin
            if (out_valid && !out_stall)
            begin
                if (filtered_q.size() == 0)
                begin
                    $display("%0t: result %02h with no transaction expected", $time, out_char);
                    error_count++;
                end
                else
                begin
                    want = filtered_q.pop_front();
                    if (out_char !== want.ch)
                    begin
                        $display("%0t: out_char expected %02h, got %02h",
                                 $time, want.ch, out_char);
                        error_count++;
                    end
                    if (run_last !== want.is_last)
                    begin
                        $display("%0t: run_last expected %0b, got %0b",
                                 $time, want.is_last, run_last);
                        error_count++;
                    end
                    results_checked++;
                end
            end
            out_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_c_comment_whitespace_stripper: errors");
            $finish;
        end
    end

    initial
    begin
        int pick;
        int len;
        int r;

        clear_scanner();
        foreach (directed_rows[i])
            stim_q.push_back(directed_rows[i]);

        while (stim_q.size() < NUM_DIRECTED + RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            len = $urandom_range(6);
            if (pick < 22)
            begin
                for (int j = 0; j <= len; j++)
                    add_byte($urandom_range(1) ? 8'($urandom_range(8'h61, 8'h7A))
                                               : 8'($urandom_range(8'h21, 8'h7E)));
            end
            else if (pick < 36)
            begin
                for (int j = 0; j <= len % 4; j++)
                begin
                    r = $urandom_range(3);
                    add_byte(r == 0 ? CH_SPACE : r == 1 ? CH_TAB : r == 2 ? CH_LF : CH_CR);
                end
            end
            else if (pick < 46)
            begin
                add_byte(CH_SLASH);
                add_byte(CH_SLASH);
                for (int j = 0; j < len; j++)
                    add_byte($urandom_range(3) == 0 ? CH_STAR : printable());
                add_byte(CH_LF);
            end
            else if (pick < 58)
            begin
                add_byte(CH_SLASH);
                add_byte(CH_STAR);
                for (int j = 0; j < len; j++)
                begin
                    r = $urandom_range(5);
                    add_byte(r == 0 ? CH_STAR : r == 1 ? CH_LF : printable());
                end
                add_byte(CH_STAR);
                add_byte(CH_SLASH);
            end
            else if (pick < 72)
            begin
                add_byte(CH_QUOTE);
                for (int j = 0; j < len; j++)
                begin
                    r = $urandom_range(9);
                    if (r == 0)
                    begin
                        add_byte(CH_BACKSLASH);
                        add_byte(CH_QUOTE);
                    end
                    else if (r == 1)
                        add_byte(CH_SLASH);
                    else
                        add_byte(printable());
                end
                add_byte(CH_QUOTE);
            end
            else if (pick < 78)
            begin
                add_byte(CH_TICK);
                add_byte(CH_QUOTE);
                add_byte(CH_TICK);
            end
            else if (pick < 86)
            begin
                add_byte(CH_SLASH);
                add_byte($urandom_range(3) == 0 ? CH_SPACE : printable());
            end
            else if (pick < 95)
            begin
                for (int j = 0; j <= len % 3; j++)
                    add_byte(8'($urandom_range(255)));
            end
            else
            begin
                r = $urandom_range(2);
                if (r == 0)
                    add_byte(CH_SLASH);
                else if (r == 1)
                begin
                    add_byte(CH_SLASH);
                    add_byte(CH_STAR);
                    for (int j = 0; j < len; j++)
                        add_byte(8'($urandom_range(255)));
                end
                add_end();
            end
        end

        repeat (3) @(posedge clk);
        rst_n   <= 1'b1;
        running <= 1'b1;

        while (accepted_items < stim_q.size())
            @(posedge clk);
        while (filtered_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d output bytes from %0d input transactions, %0d end-of-stream;",
                 results_checked, accepted_items, end_items);
        $display("code, blanks, both comment styles, strings, quote literals, held slashes.");
        if (error_count == 0)
            $display("tb_c_comment_whitespace_stripper: clean");
        else
            $display("tb_c_comment_whitespace_stripper: errors");
        $finish;
    end

endmodule

// File: files.f
rtl/ccws_pkg.sv
rtl/ccws_step.sv
rtl/ccws_fifo.sv
rtl/c_comment_whitespace_stripper.sv
test/tb_c_comment_whitespace_stripper.sv
